>>> rtl/priority_interrupt_controller_assert.svh
// ============================================================================
// Assertion macros for the priority interrupt controller
// Immediate-style and next-cycle checks, clocked on clk, off during reset.
// ============================================================================
`ifndef PRIORITY_INTERRUPT_CONTROLLER_ASSERT_SVH
`define PRIORITY_INTERRUPT_CONTROLLER_ASSERT_SVH

// Condition must hold at every clock edge out of reset
`define PIC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent in a cycle implies consequent in the next
`define PIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/pic_pkg.sv
// ============================================================================
// pic_pkg
// Types, codes and reset constants of the priority interrupt controller.
// ============================================================================
`timescale 1ns / 1ps

package pic_pkg;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        REQ_LINE  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2
    } req_type_t;

    // Widths of the word fields
    localparam int SRC_W  = 4;
    localparam int SEL_W  = 4;
    localparam int DATA_W = 16;
    localparam int CW_W   = 8;
    localparam int VEC_W  = 8;
    localparam int LVL_W  = 3;
    localparam int IDX_W  = 5;   // internal source index, covers up to 31 sources

    // Register selects
    localparam logic [SEL_W-1:0] SEL_MASK     = 4'd0;
    localparam logic [SEL_W-1:0] SEL_PENDING  = 4'd14;
    localparam int               MAX_CTRL_SEL = 13;

    // Configuration register indexes
    localparam logic [1:0] CFG_WATCHDOG = 2'd0;
    localparam logic [1:0] CFG_UART1    = 2'd1;
    localparam logic [1:0] CFG_UART2    = 2'd2;

    localparam logic [VEC_W-1:0] WATCHDOG_VEC_RESET = 8'd15;
    localparam logic [VEC_W-1:0] UART_VEC_RESET     = 8'd0;

    // Priority and vector constants
    localparam logic [4:0]        MIN_FIELD      = 5'd4;
    localparam logic [VEC_W-1:0]  AUTOVEC_BASE   = 8'd24;
    localparam logic [VEC_W-1:0]  DEFAULT_VECTOR = 8'h0f;
    localparam int                AUTOVEC_BIT    = 7;
    localparam logic [DATA_W-1:0] MASK_RESET     = 16'h3ffe;

    // Sources with their own programmable vector
    localparam logic [IDX_W-1:0] SRC_WATCHDOG = 5'd8;
    localparam logic [IDX_W-1:0] SRC_UART1    = 5'd12;
    localparam logic [IDX_W-1:0] SRC_UART2    = 5'd13;

    // Control word reset value per source
    function automatic logic [CW_W-1:0] ctrl_reset_value(input int n);
        logic [CW_W-1:0] v;
        case (n)
            1:       v = 8'h04;
            2:       v = 8'h08;
            3:       v = 8'h0c;
            4:       v = 8'h10;
            5:       v = 8'h14;
            6:       v = 8'h18;
            7:       v = 8'h1c;
            8:       v = 8'h1c;
            9:       v = 8'h80;
            10:      v = 8'h80;
            11:      v = 8'h80;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/priority_interrupt_controller.sv
// ============================================================================
// priority_interrupt_controller
// Pending/mask/control registers with a registered priority encoder.
// ============================================================================
// Usage:
//   Input words arrive on s_*: tuser carries the request kind (line change,
//   register write, register read), tdata the source, line state, register
//   select and write data. Each accepted word yields exactly one output word
//   on m_*: the read data (zero unless a read) and the interrupt level and
//   vector for the register state after that word.
//   The state is updated at the edge that accepts the word; the request stage
//   then holds the word's read data while a compare tree over all sources
//   feeds the output register, which loads the result once it is free.
//   Throughput is one word per cycle while m_tready is high; the two register
//   stages (request stage, output register) let a new word in while a result waits.
//   When m_tready is low the output holds; once both stages are full,
//   s_tready drops until the output is taken.
//   Reset sets the mask to all sources masked, clears pending bits, loads the
//   control word defaults and the vector registers, and empties both stages.
//   cfg_* writes the vector registers (watchdog, UART1, UART2) at once.
// ============================================================================
`timescale 1ns / 1ps

module priority_interrupt_controller #(
    parameter int NUM_SOURCES = 13
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input word
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // source[3:0], line_level[4], reg_sel[8:5],
                                   // write_data[24:9], zero fill
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    // Output word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_data[15:0], irq_level[18:16],
                                   // irq_vector[26:19], zero fill
    // Configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int NCTRL  = (NUM_SOURCES < pic_pkg::MAX_CTRL_SEL) ?
                            NUM_SOURCES : pic_pkg::MAX_CTRL_SEL;
    localparam int LEAVES = 2 ** $clog2(NUM_SOURCES + 1);

    // Compare tree node
    typedef struct packed {
        logic                          active;
        logic [pic_pkg::CW_W-1:0]      cw;
        logic [pic_pkg::IDX_W-1:0]     idx;
    } node_t;

    // Input field unpack
    pic_pkg::req_type_t             req;
    logic [pic_pkg::SRC_W-1:0]      src;
    logic                           line_level;
    logic [pic_pkg::SEL_W-1:0]      sel;
    logic [pic_pkg::DATA_W-1:0]     wdata;

    assign req        = pic_pkg::req_type_t'(s_tuser);
    assign src        = s_tdata[3:0];
    assign line_level = s_tdata[4];
    assign sel        = s_tdata[8:5];
    assign wdata      = s_tdata[24:9];

    // State
    logic [NUM_SOURCES:0]           pending_reg, pending_next;
    logic [pic_pkg::DATA_W-1:0]     mask_reg, mask_next;
    logic [pic_pkg::CW_W-1:0]       ctrl_reg  [1:NCTRL];
    logic [pic_pkg::CW_W-1:0]       ctrl_next [1:NCTRL];
    logic [pic_pkg::VEC_W-1:0]      wdog_vec_reg, uart1_vec_reg, uart2_vec_reg;

    // Pipeline
    logic                           s1_valid_reg;
    logic [pic_pkg::DATA_W-1:0]     s1_rd_reg, rd_next;
    logic                           out_valid_reg;
    logic [pic_pkg::DATA_W-1:0]     out_rd_reg;
    logic [pic_pkg::LVL_W-1:0]      out_level_reg, level_next;
    logic [pic_pkg::VEC_W-1:0]      out_vector_reg, vector_next;

    logic                           advance;
    logic                           accept;
    logic [pic_pkg::DATA_W-1:0]     pend16;
    logic                           src_ok;
    logic                           ctrl_ok;
    node_t                          tree [1:2*LEAVES-1];
    node_t                          winner;

    // Handshake
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_vector_reg, out_level_reg, out_rd_reg};

    // Pending bits as seen on a 16-bit read
    for (genvar b = 0; b < pic_pkg::DATA_W; b++) begin : g_pend16
        if (b <= NUM_SOURCES) begin : g_bit
            assign pend16[b] = pending_reg[b];
        end
        else begin : g_zero
            assign pend16[b] = 1'b0;
        end
    end

    assign src_ok  = {1'b0, src} inside {[1:NUM_SOURCES]};
    assign ctrl_ok = sel inside {[1:NCTRL]};

    // Request decode: state update and read data
    always_comb
    begin
        pending_next = pending_reg;
        mask_next    = mask_reg;
        ctrl_next    = ctrl_reg;
        rd_next      = '0;
        case (req)
            pic_pkg::REQ_LINE:
            begin
                if (src_ok) begin
                    for (int k = 1; k <= NUM_SOURCES; k++) begin
                        if ({1'b0, src} == 5'(k))
                            pending_next[k] = line_level;
                    end
                end
            end
            pic_pkg::REQ_WRITE:
            begin
                if (sel == pic_pkg::SEL_MASK)
                    mask_next = wdata;
                else if (ctrl_ok) begin
                    for (int k = 1; k <= NCTRL; k++) begin
                        if (sel == 4'(k))
                            ctrl_next[k] = wdata[pic_pkg::CW_W-1:0];
                    end
                end
            end
            pic_pkg::REQ_READ:
            begin
                if (sel == pic_pkg::SEL_MASK)
                    rd_next = mask_reg;
                else if (ctrl_ok) begin
                    for (int k = 1; k <= NCTRL; k++) begin
                        if (sel == 4'(k))
                            rd_next = {8'd0, ctrl_reg[k]};
                    end
                end
                else if (sel == pic_pkg::SEL_PENDING)
                    rd_next = pend16;
            end
            default:
            begin
                rd_next = '0;
            end
        endcase
    end

    // Tree leaves: one per source, leaf 0 and padding never active
    for (genvar k = 0; k < LEAVES; k++) begin : g_leaf
        if (k >= 1 && k <= NUM_SOURCES) begin : g_src
            logic                     masked;
            logic [pic_pkg::CW_W-1:0] cw;
            if (k < pic_pkg::DATA_W) begin : g_mask
                assign masked = mask_reg[k];
            end
            else begin : g_nomask
                assign masked = 1'b0;
            end
            if (k <= NCTRL) begin : g_cw
                assign cw = ctrl_reg[k];
            end
            else begin : g_nocw
                assign cw = '0;
            end
            assign tree[LEAVES+k] = '{active: pending_reg[k] && !masked,
                                      cw: cw, idx: 5'(k)};
        end
        else begin : g_pad
            assign tree[LEAVES+k] = '{active: 1'b0, cw: '0, idx: 5'(k)};
        end
    end

    // Tree nodes: larger field wins, the lower source on a tie
    for (genvar i = 1; i < LEAVES; i++) begin : g_node
        node_t l, r;
        assign l = tree[2*i];
        assign r = tree[2*i+1];
        assign tree[i] = (r.active && (!l.active || r.cw[4:0] > l.cw[4:0])) ? r : l;
    end

    assign winner = tree[1];

    // Level and vector of the winner
    always_comb
    begin
        level_next  = '0;
        vector_next = '0;
        if (winner.active && winner.cw[4:0] >= pic_pkg::MIN_FIELD) begin
            level_next = winner.cw[4:2];
            if (winner.cw[pic_pkg::AUTOVEC_BIT])
                vector_next = pic_pkg::AUTOVEC_BASE + {5'd0, winner.cw[4:2]};
            else if (winner.idx == pic_pkg::SRC_WATCHDOG)
                vector_next = wdog_vec_reg;
            else if (winner.idx == pic_pkg::SRC_UART1)
                vector_next = uart1_vec_reg;
            else if (winner.idx == pic_pkg::SRC_UART2)
                vector_next = uart2_vec_reg;
            else
                vector_next = pic_pkg::DEFAULT_VECTOR;
        end
    end

    // Register state, updated at acceptance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pending_reg <= '0;
            mask_reg    <= pic_pkg::MASK_RESET;
            for (int k = 1; k <= NCTRL; k++)
                ctrl_reg[k] <= pic_pkg::ctrl_reset_value(k);
        end
        else if (accept) begin
            pending_reg <= pending_next;
            mask_reg    <= mask_next;
            ctrl_reg    <= ctrl_next;
        end
    end

    // Vector configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wdog_vec_reg  <= pic_pkg::WATCHDOG_VEC_RESET;
            uart1_vec_reg <= pic_pkg::UART_VEC_RESET;
            uart2_vec_reg <= pic_pkg::UART_VEC_RESET;
        end
        else if (cfg_we) begin
            case (cfg_index)
                pic_pkg::CFG_WATCHDOG: wdog_vec_reg  <= cfg_data;
                pic_pkg::CFG_UART1:    uart1_vec_reg <= cfg_data;
                pic_pkg::CFG_UART2:    uart2_vec_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Request stage and output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (s_tready)
                s1_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_rd_reg <= rd_next;
        if (advance && s1_valid_reg) begin
            out_rd_reg     <= s1_rd_reg;
            out_level_reg  <= level_next;
            out_vector_reg <= vector_next;
        end
    end

`include "priority_interrupt_controller_assert.svh"

    `PIC_ASSERT_ALWAYS(a_full_stall, !(s1_valid_reg && out_valid_reg && !m_tready) || !s_tready, "input accepted while both stages are full")
    `PIC_ASSERT_NEXT(a_mask_write, accept && req == pic_pkg::REQ_WRITE && sel == pic_pkg::SEL_MASK, mask_reg == $past(wdata), "mask write not applied")
    `PIC_ASSERT_ALWAYS(a_none_vector, !(out_valid_reg && out_level_reg == 3'd0) || out_vector_reg == 8'd0, "vector given without a request level")
    `PIC_ASSERT_NEXT(a_no_phantom, !s1_valid_reg && advance, !out_valid_reg, "output word without a request")

endmodule

>>> tb/tb_priority_interrupt_controller.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_priority_interrupt_controller
// Stream-level check of the priority interrupt controller. Request words
// (line changes, register writes and reads) go in with random gaps, and the
// output is stalled at random. A scoreboard keeps its own copy of the pending,
// mask and control registers, predicts the read data, level and vector of
// every request, and compares each output word in order.
// ============================================================================

module tb_priority_interrupt_controller;

    localparam int          N_SRC       = 13;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          LONG_HOLD   = 60;
    localparam logic [1:0]  REQ_UNUSED  = 2'd3;

    // Control word defaults for sources 1..13
    localparam logic [7:0] CTRL_DEFAULTS [N_SRC] = '{
        8'h04, 8'h08, 8'h0c, 8'h10, 8'h14, 8'h18, 8'h1c,
        8'h1c, 8'h80, 8'h80, 8'h80, 8'h00, 8'h00
    };

    typedef struct {
        logic [15:0] read_data;
        logic [2:0]  irq_level;
        logic [7:0]  irq_vector;
    } irq_outcome_t;

    // ------------------------------------------------------------------------
    // Scoreboard: register shadow, interrupt resolution and expected words
    // ------------------------------------------------------------------------
    class irq_outcome_board;
        logic [7:0]   ctrl_word [1:N_SRC];
        logic [15:0]  mask_reg;
        logic [N_SRC:0] pend_reg;   // bit n is source n, bit 0 unused
        logic [7:0]   wdog_vec;
        logic [7:0]   uart1_vec;
        logic [7:0]   uart2_vec;
        irq_outcome_t outcome_q [$];
        int           mismatches;
        int           requests;
        int           checked;

        function new();
            for (int n = 1; n <= N_SRC; n++)
                ctrl_word[n] = CTRL_DEFAULTS[n-1];
            mask_reg   = pic_pkg::MASK_RESET;
            pend_reg   = '0;
            wdog_vec   = pic_pkg::WATCHDOG_VEC_RESET;
            uart1_vec  = pic_pkg::UART_VEC_RESET;
            uart2_vec  = pic_pkg::UART_VEC_RESET;
            mismatches = 0;
            requests   = 0;
            checked    = 0;
        endfunction

        function void set_vector(logic [1:0] idx, logic [7:0] value);
            case (idx)
                pic_pkg::CFG_WATCHDOG: wdog_vec  = value;
                pic_pkg::CFG_UART1:    uart1_vec = value;
                pic_pkg::CFG_UART2:    uart2_vec = value;
                default:               ;
            endcase
        endfunction

        // Highest 5-bit field among pending, unmasked sources; lowest wins ties
        function void resolve_irq(output logic [2:0] level, output logic [7:0] vector);
            logic [4:0] best;
            int         winner;
            logic [7:0] cw;
            best   = '0;
            winner = 0;
            level  = '0;
            vector = '0;
            for (int n = 1; n <= N_SRC; n++) begin
                if (pend_reg[n] && !mask_reg[n] && ctrl_word[n][4:0] > best) begin
                    best   = ctrl_word[n][4:0];
                    winner = n;
                end
            end
            if (winner != 0 && best >= pic_pkg::MIN_FIELD) begin
                cw    = ctrl_word[winner];
                level = cw[4:2];
                if (cw[pic_pkg::AUTOVEC_BIT])
                    vector = pic_pkg::AUTOVEC_BASE + 8'(level);
                else if (winner == int'(pic_pkg::SRC_WATCHDOG))
                    vector = wdog_vec;
                else if (winner == int'(pic_pkg::SRC_UART1))
                    vector = uart1_vec;
                else if (winner == int'(pic_pkg::SRC_UART2))
                    vector = uart2_vec;
                else
                    vector = pic_pkg::DEFAULT_VECTOR;
            end
        endfunction

        // Apply an accepted request word and queue its expected output
        function void note_request(logic [1:0] kind, logic [31:0] word);
            logic [3:0]   src;
            logic         lvl;
            logic [3:0]   sel;
            logic [15:0]  wd;
            irq_outcome_t exp_o;
            src = word[3:0];
            lvl = word[4];
            sel = word[8:5];
            wd  = word[24:9];
            exp_o.read_data = '0;
            case (kind)
                pic_pkg::REQ_LINE:
                    if (src >= 1 && src <= N_SRC)
                        pend_reg[src] = lvl;
                pic_pkg::REQ_WRITE:
                    if (sel == pic_pkg::SEL_MASK)
                        mask_reg = wd;
                    else if (sel <= pic_pkg::MAX_CTRL_SEL)
                        ctrl_word[sel] = wd[7:0];
                pic_pkg::REQ_READ:
                    if (sel == pic_pkg::SEL_MASK)
                        exp_o.read_data = mask_reg;
                    else if (sel <= pic_pkg::MAX_CTRL_SEL)
                        exp_o.read_data = {8'h00, ctrl_word[sel]};
                    else if (sel == pic_pkg::SEL_PENDING)
                        exp_o.read_data = 16'(pend_reg);
                default: ;
            endcase
            resolve_irq(exp_o.irq_level, exp_o.irq_vector);
            outcome_q.push_back(exp_o);
            requests++;
        endfunction

        function void check_outcome(logic [31:0] word);
            irq_outcome_t exp_o;
            if (outcome_q.size() == 0) begin
                $error("output word %08h with no request outstanding", word);
                mismatches++;
                return;
            end
            exp_o = outcome_q.pop_front();
            checked++;
            if (word[15:0] !== exp_o.read_data) begin
                $error("read_data: expected %04h, got %04h", exp_o.read_data, word[15:0]);
                mismatches++;
            end
            if (word[18:16] !== exp_o.irq_level) begin
                $error("irq_level: expected %0d, got %0d", exp_o.irq_level, word[18:16]);
                mismatches++;
            end
            if (word[26:19] !== exp_o.irq_vector) begin
                $error("irq_vector: expected %0d, got %0d", exp_o.irq_vector, word[26:19]);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return outcome_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    irq_outcome_board sb;
    int  cycle_count;
    bit  send_idle;
    bit  recv_idle;
    bit  hold_req;
    int  vector_settings;

    priority_interrupt_controller #(.NUM_SOURCES(N_SRC)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [1:0] kind, input logic [3:0] src,
                                input logic lvl, input logic [3:0] sel,
                                input logic [15:0] wd);
        int          gap;
        logic [31:0] word;
        word = {7'b0, wd, sel, lvl, src};
        if ($urandom_range(0, 39) == 0)
            send_idle = !send_idle;
        gap = send_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(kind, word);
    endtask

    task automatic send_random_request();
        int         pick;
        logic [1:0] kind;
        logic [3:0] src;
        logic       lvl;
        logic [3:0] sel;
        logic [15:0] wd;
        pick = $urandom_range(0, 99);
        src  = 4'($urandom_range(1, N_SRC));
        lvl  = ($urandom_range(0, 9) < 6);
        sel  = 4'($urandom_range(0, 15));
        wd   = 16'($urandom);
        if (pick < 45)
        begin
            kind = pic_pkg::REQ_LINE;
            if ($urandom_range(0, 19) == 0)
                src = 4'($urandom_range(0, 15));   // out-of-range sources now and then
        end
        else if (pick < 75)
        begin
            kind = pic_pkg::REQ_WRITE;
            pick = $urandom_range(0, 9);
            if (pick < 2)
            begin
                sel = pic_pkg::SEL_MASK;
                // keep most sources unmasked so the compare tree has work
                case ($urandom_range(0, 3))
                    0:       wd = 16'($urandom);
                    3:       wd = '0;
                    default: wd = 16'($urandom & $urandom & $urandom);
                endcase
            end
            else if (pick < 9)
                sel = 4'($urandom_range(1, pic_pkg::MAX_CTRL_SEL));
            else
                sel = 4'($urandom_range(14, 15));
        end
        else if (pick < 97)
            kind = pic_pkg::REQ_READ;
        else
            kind = REQ_UNUSED;
        send_request(kind, src, lvl, sel, wd);
    endtask

    // Drop valid, let every outstanding word drain, then settle
    task automatic drain_output();
        s_tvalid <= 1'b0;
        while (sb.outstanding() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all three vector registers; block must be idle
    task automatic set_vectors(input logic [7:0] wdog, input logic [7:0] u1,
                               input logic [7:0] u2);
        logic [7:0] vals [3];
        vals = '{wdog, u1, u2};
        for (int i = 0; i < 3; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            sb.set_vector(2'(i), vals[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        vector_settings++;
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls, one long hold on request
    // ------------------------------------------------------------------------
    initial
    begin
        int stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                recv_idle = !recv_idle;
            if (hold_req)
            begin
                stall    = LONG_HOLD;
                hold_req = 1'b0;
            end
            else
                stall = recv_idle ? $urandom_range(0, 9) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check_outcome(m_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb              = new();
        send_idle       = 1'b1;
        recv_idle       = 1'b1;
        hold_req        = 1'b0;
        vector_settings = 0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset values, ties, autovector, per-source vectors, ignores
        send_request(pic_pkg::REQ_READ,  4'd0,  1'b0, pic_pkg::SEL_MASK,    16'h0000);
        send_request(pic_pkg::REQ_READ,  4'd0,  1'b0, pic_pkg::SEL_PENDING, 16'hffff);
        send_request(pic_pkg::REQ_READ,  4'd0,  1'b0, 4'd1,                 16'h0000);
        send_request(pic_pkg::REQ_READ,  4'd0,  1'b0, 4'd13,                16'h0000);
        send_request(pic_pkg::REQ_WRITE, 4'd0,  1'b0, pic_pkg::SEL_MASK,    16'h0000);
        // field below minimum
        send_request(pic_pkg::REQ_LINE,  4'd9,  1'b1, 4'd0,                 16'h0000);
        // default vector
        send_request(pic_pkg::REQ_LINE,  4'd7,  1'b1, 4'd0,                 16'h0000);
        // tie, lower wins
        send_request(pic_pkg::REQ_LINE,  4'd8,  1'b1, 4'd0,                 16'h0000);
        // watchdog wins
        send_request(pic_pkg::REQ_WRITE, 4'd0,  1'b0, 4'd7,                 16'hff00);
        send_request(pic_pkg::REQ_LINE,  4'd0,  1'b1, 4'd0,                 16'h0000);
        send_request(pic_pkg::REQ_LINE,  4'd14, 1'b1, 4'd0,                 16'h0000);
        send_request(pic_pkg::REQ_LINE,  4'd15, 1'b1, 4'd15,                16'hffff);
        // autovector 31
        send_request(pic_pkg::REQ_WRITE, 4'd0,  1'b0, 4'd12,                16'hffff);
        send_request(pic_pkg::REQ_LINE,  4'd12, 1'b1, 4'd0,                 16'h0000);
        send_request(pic_pkg::REQ_WRITE, 4'd0,  1'b0, 4'd13,                16'h001f);
        send_request(pic_pkg::REQ_LINE,  4'd13, 1'b1, 4'd0,                 16'h0000);
        // uart2 vector
        send_request(pic_pkg::REQ_WRITE, 4'd0,  1'b0, 4'd12,                16'h0000);
        send_request(pic_pkg::REQ_WRITE, 4'd0,  1'b0, pic_pkg::SEL_PENDING, 16'hffff);
        send_request(pic_pkg::REQ_WRITE, 4'd0,  1'b0, 4'd15,                16'hffff);
        send_request(pic_pkg::REQ_READ,  4'd0,  1'b0, 4'd15,                16'h0000);
        send_request(pic_pkg::REQ_READ,  4'd0,  1'b0, pic_pkg::SEL_PENDING, 16'h0000);
        send_request(REQ_UNUSED,         4'd5,  1'b1, pic_pkg::SEL_MASK,    16'h1234);
        send_request(pic_pkg::REQ_WRITE, 4'd0,  1'b0, pic_pkg::SEL_MASK,    16'hffff);
        send_request(pic_pkg::REQ_WRITE, 4'd0,  1'b0, pic_pkg::SEL_MASK,    16'h0000);
        send_request(pic_pkg::REQ_LINE,  4'd13, 1'b0, 4'd0,                 16'h0000);
        drain_output();

        // Random phases, each under its own vector setting
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       set_vectors(8'h00, 8'h00, 8'h00);
                1:       set_vectors(8'hff, 8'hff, 8'hff);
                default: set_vectors(8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            if (phase == 2)
            begin
                // back-to-back words into a stalled output
                hold_req  = 1'b1;
                send_idle = 1'b0;
            end
            repeat (170) send_random_request();
            drain_output();
        end

        repeat (10) @(posedge clk);
        $display("Checked %0d output words for %0d requests across %0d vector settings,",
                 sb.checked, sb.requests, vector_settings);
        $display("with random gaps, a long output hold and full drains between phases.");
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> priority_interrupt_controller.f
+incdir+rtl
rtl/pic_pkg.sv
rtl/priority_interrupt_controller.sv
tb/tb_priority_interrupt_controller.sv
